[rtl/pae_pkg.sv]
// Package for the polynomial accumulate/evaluate block.
// Holds the payload structs, opcodes, FSM states and cell and multiply-add control types.
// No dependencies.
`default_nettype none

package pae_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DegW  = 6;

  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpEval  = 2'd1,
    OpClear = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [DegW-1:0]         term_degree;
    logic signed [DataW-1:0] term_coefficient;
    logic signed [DataW-1:0] point;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] poly_value;
    logic                    status;
  } out_t;

  // Broadcast to every cell of the coefficient ring.
  typedef struct packed {
    logic             shift;
    logic             clear;
    logic             add;
    logic [DegW-1:0]  degree;
    logic [DataW-1:0] coef;
  } cell_ctrl_t;

  // Horner multiply-add unit control.
  typedef struct packed {
    logic load;
    logic step;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/polynomial_accumulate_evaluate.sv]
// Polynomial accumulate/evaluate. The polynomial lives in a ring of MAX_DEGREE
// coefficient cells, one per degree, all zero after reset. Add (opcode 0) adds
// term_coefficient into the cell of term_degree; a degree of MAX_DEGREE or more
// leaves the table alone and returns status 1. Clear (opcode 2) zeroes every
// cell at once. Evaluate (opcode 1) rotates the ring one cell per cycle past a
// single 32x32 multiply-add unit, which applies Horner's rule from the top
// degree down; after MAX_DEGREE rotations the ring is back in place. Every
// transaction yields one result: poly_value (mod 2^32, zero unless evaluate)
// and status. Evaluate goes through accept, MAX_DEGREE multiply-add steps on
// the one shared multiply-add unit, then hand-off to the output register; add,
// clear and the unused opcode go from accept straight to the hand-off.
// One transaction is in work at a time; the output register holds a finished
// result while a stalled consumer waits, and in_stall_o is low whenever the
// engine is idle.
// Depends on pae_pkg, pae_cell, pae_horner.
`default_nettype none

module polynomial_accumulate_evaluate #(
  parameter int unsigned MAX_DEGREE = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pae_pkg::in_t  in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pae_pkg::out_t      out_o
);

  localparam int unsigned CntW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_DEGREE - 1);

  pae_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                status_q, status_d;
  logic                out_valid_q;
  pae_pkg::out_t       out_q;
  logic                out_load;
  logic                accept;

  pae_pkg::cell_ctrl_t cell_ctrl;
  pae_pkg::mac_ctrl_t  mac_ctrl;
  logic [pae_pkg::DataW-1:0] ring [MAX_DEGREE];
  logic [pae_pkg::DataW-1:0] acc;

  assign in_stall_o = (state_q != pae_pkg::StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Coefficient ring: cell i takes from cell i-1 on shift, cell 0 from the top,
  // so the top cell presents degrees MAX_DEGREE-1 down to 0 in turn.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_cell
    logic [pae_pkg::DataW-1:0] src;
    if (i == 0) begin : g_wrap
      assign src = ring[MAX_DEGREE-1];
    end else begin : g_link
      assign src = ring[i-1];
    end
    pae_cell #(
      .CellIdx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .shift_i(src),
      .coef_o (ring[i])
    );
  end

  pae_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .point_i(in_i.point),
    .coef_i (ring[MAX_DEGREE-1]),
    .acc_o  (acc)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pae_pkg::StIdle;
      cnt_q    <= '0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    status_d         = status_q;
    out_load         = 1'b0;
    cell_ctrl.shift  = 1'b0;
    cell_ctrl.clear  = 1'b0;
    cell_ctrl.add    = 1'b0;
    cell_ctrl.degree = in_i.term_degree;
    cell_ctrl.coef   = in_i.term_coefficient;
    mac_ctrl.load    = 1'b0;
    mac_ctrl.step    = 1'b0;
    case (state_q)
      pae_pkg::StIdle: begin
        if (accept) begin
          // Accumulator cleared on every transaction: non-evaluate results read 0.
          mac_ctrl.load = 1'b1;
          cnt_d         = '0;
          status_d      = 1'b0;
          state_d       = pae_pkg::StDone;
          case (in_i.opcode)
            pae_pkg::OpAdd: begin
              // Cells only match in-range degrees, so out-of-range is a no-op.
              cell_ctrl.add = 1'b1;
              status_d      = (32'(in_i.term_degree) >= MAX_DEGREE);
            end
            pae_pkg::OpEval: begin
              state_d = pae_pkg::StEval;
            end
            pae_pkg::OpClear: begin
              cell_ctrl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      pae_pkg::StEval: begin
        cell_ctrl.shift = 1'b1;
        mac_ctrl.step   = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = pae_pkg::StDone;
        end
      end
      pae_pkg::StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = pae_pkg::StIdle;
        end
      end
      default: begin
        state_d = pae_pkg::StIdle;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.poly_value <= acc;
      out_q.status     <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pae_pkg::StDone))
    else $error("result appeared without a finished transaction");

  a_status_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status) |-> (out_q.poly_value == '0))
    else $error("rejected add returned a nonzero value");

  a_eval_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pae_pkg::StEval && cnt_q != CntLast) |=>
      (state_q == pae_pkg::StEval && cnt_q == CntW'($past(cnt_q) + 1'b1)))
    else $error("evaluation step counter skipped");

  a_eval_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pae_pkg::StEval && cnt_q == CntLast) |=>
      (state_q == pae_pkg::StDone && cnt_q == '0))
    else $error("evaluation did not end after the last degree");

endmodule

`default_nettype wire

[rtl/pae_cell.sv]
// One coefficient cell of the ring: holds the coefficient of one degree.
// Uses pae_pkg for the control struct.
`default_nettype none

module pae_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pae_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [pae_pkg::DataW-1:0] shift_i,
  output logic      [pae_pkg::DataW-1:0] coef_o
);

  logic [pae_pkg::DataW-1:0] coef_q, coef_d;
  logic                      match;

  assign match = (32'(ctrl_i.degree) == CellIdx);

  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.clear) begin
      coef_d = '0;
    end else if (ctrl_i.shift) begin
      coef_d = shift_i;
    end else if (ctrl_i.add && match) begin
      coef_d = coef_q + ctrl_i.coef;  // wraps mod 2^32
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

[rtl/pae_horner.sv]
// Horner multiply-add unit: acc = acc * x + c, one step per cycle while step is set.
// Uses pae_pkg for the control struct.
`default_nettype none

module pae_horner (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pae_pkg::mac_ctrl_t        ctrl_i,
  input  wire logic [pae_pkg::DataW-1:0] point_i,
  input  wire logic [pae_pkg::DataW-1:0] coef_i,
  output logic      [pae_pkg::DataW-1:0] acc_o
);

  logic [pae_pkg::DataW-1:0] acc_q, acc_d;
  logic [pae_pkg::DataW-1:0] x_q, x_d;
  logic [pae_pkg::DataW-1:0] prod;

  // Only the low word of the product matters.
  assign prod = acc_q * x_q;

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    if (ctrl_i.load) begin
      acc_d = '0;
      x_d   = point_i;
    end else if (ctrl_i.step) begin
      acc_d = prod + coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      x_q   <= '0;
    end else begin
      acc_q <= acc_d;
      x_q   <= x_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire
